FILE: rtl/dq_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes and status codes of the double-ended queue.
package dq_pkg;

    localparam int DQ_DEPTH = 64;
    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // Command codes on the request channel
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    // Status codes on the response channel
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_DUMP
    } dq_op_t;

    typedef struct packed {
        dq_op_t                    op;
        logic signed [WORD_W-1:0]  value;
    } dq_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DUMP,
        S_DUMP_DATA
    } dq_state_t;

endpackage

FILE: rtl/dq_cmd_if.sv
`timescale 1ns / 1ps
// Request channel: command code and word to push.
interface dq_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [dq_pkg::CMD_W-1:0]          cmd;
    logic signed [dq_pkg::WORD_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

FILE: rtl/dq_res_if.sv
`timescale 1ns / 1ps
// Response channel: returned word, status and end-of-command mark.
interface dq_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [dq_pkg::WORD_W-1:0]  word;
    logic [dq_pkg::STATUS_W-1:0]       status;
    logic                              last;

    modport source (output valid, output word, output status, output last, input ready);
    modport sink   (input valid, input word, input status, input last, output ready);
endinterface

FILE: rtl/dq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dq_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, decodes them and buffers them in a two-entry queue.
module dq_front (
    input  logic              clk,
    input  logic              rst_n,
    dq_cmd_if.sink            req,
    output logic              q_valid,
    input  logic              q_ready,
    output dq_pkg::dq_entry_t q_entry
);
    import dq_pkg::*;

    localparam logic [1:0] Q_FULL = 2'd2;

    dq_entry_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       accept;
    logic       keep;
    logic       take;
    logic       code_ok;
    dq_op_t     op;

    always_comb
    begin
        code_ok = 1'b1;
        case (req.cmd)
            CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
            CMD_PUSH_BACK:  op = OP_PUSH_BACK;
            CMD_POP_FRONT:  op = OP_POP_FRONT;
            CMD_POP_BACK:   op = OP_POP_BACK;
            CMD_DUMP:       op = OP_DUMP;
            default:
            begin
                op      = OP_DUMP;
                code_ok = 1'b0;
            end
        endcase
    end

    assign req.ready = (cnt_reg != Q_FULL);
    assign accept    = req.valid && req.ready;
    // drop unused codes at the door: they produce no transaction
    assign keep      = accept && code_ok;
    assign q_valid   = (cnt_reg != 2'd0);
    assign take      = q_valid && q_ready;
    assign q_entry   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = keep ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, keep} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            entry_reg[wr_ptr_reg].op    <= op;
            entry_reg[wr_ptr_reg].value <= req.value;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_FULL)
        else $error("front queue count out of range");

    a_cnt_move: assert property (@(posedge clk) disable iff (!rst_n)
        (keep && !take) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("front queue count missed a push");

    a_bad_code_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !code_ok && !take) |=> $stable(cnt_reg))
        else $error("unused command code entered the queue");

endmodule

FILE: rtl/dq_back.sv
`timescale 1ns / 1ps
// Back end: executes queued commands on the ring store and drives the response register.
module dq_back #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  dq_pkg::dq_entry_t q_entry,
    dq_res_if.source          rsp
);
    import dq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SW    = IDX_W + 1;
    localparam logic [SW-1:0]    DEPTH_S = SW'(DEPTH);
    localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(DEPTH - 1);

    dq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   dump_cnt_reg, dump_cnt_next;
    logic               last_pend_reg, last_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [WORD_W-1:0] out_word_reg, out_word_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    logic               out_free;
    logic               is_full;
    logic               is_empty;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [SW-1:0]    offs);
        logic [SW-1:0] sum;
        sum = SW'(base) + offs;
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_entry.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || rsp.ready;
    assign is_full  = (occ_reg == FULL_C);
    assign is_empty = (occ_reg == '0);

    assign rsp.valid  = out_valid_reg;
    assign rsp.word   = out_word_reg;
    assign rsp.status = out_status_reg;
    assign rsp.last   = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        occ_next        = occ_reg;
        dump_cnt_next   = dump_cnt_reg;
        last_pend_next  = last_pend_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        q_ready         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = front_reg;
        ram_raddr       = front_reg;

        // drain the response register
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_ready         = 1'b1;
                    out_word_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = ST_OK;
                    case (q_entry.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                occ_next = occ_reg + CNT_W'(1);
                                if (q_entry.op == OP_PUSH_FRONT)
                                begin
                                    ram_waddr  = (front_reg == '0) ? TOP_IDX
                                                 : front_reg - IDX_W'(1);
                                    front_next = ram_waddr;
                                end
                                else
                                begin
                                    ram_waddr = ring_add(front_reg, SW'(occ_reg));
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                occ_next       = occ_reg - CNT_W'(1);
                                last_pend_next = 1'b1;
                                state_next     = S_READ;
                                if (q_entry.op == OP_POP_FRONT)
                                begin
                                    ram_raddr  = front_reg;
                                    front_next = ring_add(front_reg, SW'(1));
                                end
                                else
                                begin
                                    ram_raddr = ring_add(front_reg,
                                                         SW'(occ_reg - CNT_W'(1)));
                                end
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                dump_cnt_next = '0;
                                state_next    = S_DUMP;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !rsp.ready;
                        end
                    endcase
                end
            end
            S_READ, S_DUMP_DATA:
            begin
                // the register was drained when the read was issued
                out_valid_next  = 1'b1;
                out_word_next   = ram_rdata;
                out_status_next = ST_OK;
                out_last_next   = last_pend_reg;
                if (state_reg == S_READ || last_pend_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DUMP;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    ram_raddr      = ring_add(front_reg, SW'(dump_cnt_reg));
                    last_pend_next = (dump_cnt_reg == occ_reg - CNT_W'(1));
                    dump_cnt_next  = dump_cnt_reg + CNT_W'(1);
                    state_next     = S_DUMP_DATA;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            dump_cnt_reg  <= '0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            dump_cnt_reg  <= dump_cnt_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg   <= out_word_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_C)
        else $error("occupancy exceeds ring depth");

    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_DUMP_DATA) |=> out_valid_reg)
        else $error("read data did not reach the response register");

    a_dump_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (dump_cnt_reg < occ_reg))
        else $error("dump index past occupancy");

    a_dump_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP || state_reg == S_DUMP_DATA)
        |=> ($stable(occ_reg) && $stable(front_reg)))
        else $error("ring pointers moved during a dump");

endmodule

FILE: rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue: front end, back end and ring store.
//
//  channel | dir | fields                | one transaction
//  --------+-----+-----------------------+--------------------------------------
//  req     | in  | cmd, value            | one command (codes 5..7 are dropped)
//  rsp     | out | word, status, last    | one result; last marks end of command
//
// Push, full push, empty pop and empty dump complete in the back end's idle state; a pop
// adds S_READ, a dump S_DUMP and S_DUMP_DATA per word, for the ring RAM's registered read.
// Up to two commands wait in the front queue while the back end works or stalls.
// Reset (rst_n low, asynchronous) empties the queue; the ring contents are not cleared.
// A held response stalls the back end; the front end keeps taking commands until its
// two slots fill.
module double_ended_queue_unit #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    dq_cmd_if.sink    req,
    dq_res_if.source  rsp
);
    import dq_pkg::*;

    logic      q_valid;
    logic      q_ready;
    dq_entry_t q_entry;

    dq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry)
    );

    dq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry),
        .rsp     (rsp)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_unit: directed table, random traffic, scoreboard.
module testbench;
    import dq_pkg::*;

    localparam int IDX_W = $clog2(DQ_DEPTH);
    localparam int LONG_HOLD_CYCLES = 300;

    // Codes the block must ignore without a result
    localparam logic [CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } dq_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] value;
        logic                     typed;
        logic signed [WORD_W-1:0] word;
        logic [STATUS_W-1:0]      status;
    } dq_row_t;

    localparam int N_ROWS = 22;

    logic clk;
    logic rst_n;

    dq_cmd_if req_ch ();
    dq_res_if rsp_ch ();

    double_ended_queue_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow deque state
    logic signed [WORD_W-1:0] model_ring [DQ_DEPTH];
    logic [IDX_W-1:0]         model_front;
    logic [IDX_W:0]           model_count;

    dq_result_t step_results [$];
    dq_result_t expected_results [$];

    // Typed expectation that travels with the command on the bus
    logic                     row_typed;
    logic signed [WORD_W-1:0] row_word;
    logic [STATUS_W-1:0]      row_status;

    int unsigned mismatches;
    int unsigned cmds_taken;
    int unsigned results_seen;
    int unsigned full_seen;
    int unsigned empty_seen;
    int unsigned largest_dump;
    int unsigned burst_left;
    int unsigned holds_asked;

    dq_row_t directed_rows [N_ROWS] = '{
        '{CMD_POP_FRONT,  32'sd0,           1'b1, 32'sd0, ST_EMPTY},
        '{CMD_POP_BACK,   32'sd0,           1'b1, 32'sd0, ST_EMPTY},
        '{CMD_DUMP,       32'sd0,           1'b1, 32'sd0, ST_EMPTY},
        '{CMD_RSVD_LO,    32'sd0,           1'b0, 32'sd0, ST_OK},
        '{CMD_PUSH_FRONT, 32'sh7FFFFFFF,    1'b1, 32'sd0, ST_OK},
        '{CMD_PUSH_BACK,  32'sh80000000,    1'b1, 32'sd0, ST_OK},
        '{CMD_PUSH_FRONT, -32'sd1,          1'b1, 32'sd0, ST_OK},
        '{CMD_PUSH_BACK,  32'sd0,           1'b1, 32'sd0, ST_OK},
        '{CMD_DUMP,       32'sd0,           1'b0, 32'sd0, ST_OK},
        '{CMD_RSVD_MID,   32'sh12345678,    1'b0, 32'sd0, ST_OK},
        '{CMD_POP_FRONT,  -32'sd1,          1'b0, 32'sd0, ST_OK},
        '{CMD_POP_BACK,   32'sd0,           1'b0, 32'sd0, ST_OK},
        '{CMD_RSVD_HI,    -32'sd1,          1'b0, 32'sd0, ST_OK},
        '{CMD_POP_FRONT,  32'sd0,           1'b0, 32'sd0, ST_OK},
        '{CMD_POP_BACK,   32'sd0,           1'b0, 32'sd0, ST_OK},
        '{CMD_POP_BACK,   32'sd0,           1'b1, 32'sd0, ST_EMPTY},
        '{CMD_PUSH_BACK,  32'sh55555555,    1'b1, 32'sd0, ST_OK},
        '{CMD_PUSH_FRONT, 32'shAAAAAAAA,    1'b1, 32'sd0, ST_OK},
        '{CMD_DUMP,       32'sd0,           1'b0, 32'sd0, ST_OK},
        '{CMD_POP_BACK,   32'sd0,           1'b0, 32'sd0, ST_OK},
        '{CMD_POP_FRONT,  32'sd0,           1'b0, 32'sd0, ST_OK},
        '{CMD_DUMP,       32'sd0,           1'b1, 32'sd0, ST_EMPTY}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Compute the results of one command and advance the shadow state
    function automatic void deque_step(logic [CMD_W-1:0] c, logic signed [WORD_W-1:0] v);
        logic [IDX_W-1:0] slot;
        step_results.delete();
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (model_count >= DQ_DEPTH)
                begin
                    step_results.push_back({32'sd0, ST_FULL, 1'b1});
                end
                else
                begin
                    if (c == CMD_PUSH_FRONT)
                    begin
                        model_front = model_front - 1'b1;
                        slot = model_front;
                    end
                    else
                    begin
                        slot = model_front + IDX_W'(model_count);
                    end
                    model_ring[slot] = v;
                    model_count = model_count + 1'b1;
                    step_results.push_back({32'sd0, ST_OK, 1'b1});
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (model_count == 0)
                begin
                    step_results.push_back({32'sd0, ST_EMPTY, 1'b1});
                end
                else
                begin
                    if (c == CMD_POP_FRONT)
                    begin
                        slot = model_front;
                        model_front = model_front + 1'b1;
                    end
                    else
                    begin
                        slot = model_front + IDX_W'(model_count - 1'b1);
                    end
                    step_results.push_back({model_ring[slot], ST_OK, 1'b1});
                    model_count = model_count - 1'b1;
                end
            end
            CMD_DUMP:
            begin
                if (model_count == 0)
                begin
                    step_results.push_back({32'sd0, ST_EMPTY, 1'b1});
                end
                else
                begin
                    for (int k = 0; k < model_count; k++)
                    begin
                        slot = model_front + IDX_W'(k);
                        step_results.push_back({model_ring[slot], ST_OK,
                                                1'(k + 1 == model_count)});
                    end
                    if (model_count > largest_dump)
                    begin
                        largest_dump = 32'(model_count);
                    end
                end
            end
            default:
            begin
                // reserved codes: no result, no state change
            end
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
        begin
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end
        if (r < 88)
        begin
            return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        end
        if (r < 95)
        begin
            return CMD_DUMP;
        end
        return CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
    endfunction

    // Offer one transaction, hold until accepted, then maybe idle
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic signed [WORD_W-1:0] v,
                            input logic typed, input logic signed [WORD_W-1:0] w,
                            input logic [STATUS_W-1:0] s);
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= c;
        req_ch.value <= v;
        row_typed    <= typed;
        row_word     <= w;
        row_status   <= s;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic send_random(input int unsigned count, input int unsigned push_pct);
        repeat (count) send_cmd(pick_cmd(push_pct), rand_word(), 1'b0, 32'sd0, ST_OK);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // Response side: stall pattern, plus long hold-offs on request
    initial
    begin : rsp_side
        int unsigned cyc;
        int unsigned hold_left;
        int unsigned holds_done;
        logic [15:0] pattern;
        cyc = 0;
        hold_left = 0;
        holds_done = 0;
        pattern = '1;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
            begin
                pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            end
            if (hold_left == 0 && holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= pattern[cyc % 16];
            end
        end
    end

    // Predict on each accepted command, check each accepted result
    always @(posedge clk)
    begin : scoreboard
        dq_result_t got;
        dq_result_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                cmds_taken++;
                deque_step(req_ch.cmd, req_ch.value);
                if (row_typed)
                begin
                    expected_results.push_back({row_word, row_status, 1'b1});
                end
                else
                begin
                    foreach (step_results[i]) expected_results.push_back(step_results[i]);
                end
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.word, rsp_ch.status, rsp_ch.last};
                results_seen++;
                if (got.status == ST_FULL)
                begin
                    full_seen++;
                end
                if (got.status == ST_EMPTY)
                begin
                    empty_seen++;
                end
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%t: unexpected result word=%0d status=%0d last=%0d",
                                 $realtime, got.word, got.status, got.last);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.word !== want.word || got.status !== want.status
                        || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%t: result mismatch: ", $realtime,
                                     "expected word=%0d status=%0d last=%0d, ",
                                     want.word, want.status, want.last,
                                     "got word=%0d status=%0d last=%0d",
                                     got.word, got.status, got.last);
                        end
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned fill_count;
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cmd   <= CMD_PUSH_FRONT;
        req_ch.value <= '0;
        row_typed    <= 1'b0;
        row_word     <= '0;
        row_status   <= ST_OK;
        model_front  = '0;
        model_count  = '0;
        foreach (model_ring[i]) model_ring[i] = '0;
        mismatches   = 0;
        cmds_taken   = 0;
        results_seen = 0;
        full_seen    = 0;
        empty_seen   = 0;
        largest_dump = 0;
        burst_left   = 0;
        holds_asked  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_cmd(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
                     directed_rows[i].word, directed_rows[i].status);
        end

        send_random(8, 55);

        // Hold the response side off while commands keep coming
        holds_asked++;
        send_random(10, 70);
        wait_drained();

        // Fill to capacity, overflow, dump the full ring, refill around the wrap
        fill_count = DQ_DEPTH - model_count + 3;
        repeat (fill_count)
        begin
            send_cmd($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_word(),
                     1'b0, 32'sd0, ST_OK);
        end
        send_cmd(CMD_DUMP, rand_word(), 1'b0, 32'sd0, ST_OK);
        send_cmd(CMD_POP_FRONT, rand_word(), 1'b0, 32'sd0, ST_OK);
        send_cmd(CMD_PUSH_FRONT, rand_word(), 1'b1, 32'sd0, ST_OK);
        send_cmd(CMD_PUSH_BACK, rand_word(), 1'b1, 32'sd0, ST_FULL);

        send_random(6, 25);
        send_random(4, 10);
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Ran %0d commands and checked %0d results, largest dump %0d entries.",
                 cmds_taken, results_seen, largest_dump);
        $display("Saw %0d full pushes dropped and %0d empty reports.", full_seen, empty_seen);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: double_ended_queue_unit.f
rtl/dq_pkg.sv
rtl/dq_cmd_if.sv
rtl/dq_res_if.sv
rtl/dq_ram.sv
rtl/dq_front.sv
rtl/dq_back.sv
rtl/double_ended_queue_unit.sv
verif/testbench.sv
